[sv/bes_pkg.sv]
// Shared types and constants for the button event scanner with event queue.
// Used by bes_front, bes_back and the top level; depends on nothing else.
`default_nettype none

package bes_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int PIN_REGS = 4;
	localparam int CODE_W   = 8;
	localparam int LEVEL_W  = 4;
	localparam int TIME_W   = 32;
	localparam int DEB_W    = 16;
	localparam int CNT_W    = 4;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [CODE_W-1:0] CODE_OFFSET = 8'd8;
	localparam logic [CNT_W-1:0]  CNT_MAX     = 4'hF;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_PIN0     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PIN1     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PIN2     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PIN3     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd5;

	typedef struct packed {
		logic [PIN_REGS-1:0][CODE_W-1:0] pin_code;
		logic [DEB_W-1:0]                debounce_ms;
		logic                            events_enabled;
	} cfg_t;

	typedef struct packed {
		logic               operation;
		logic [LEVEL_W-1:0] button_levels;
		logic [TIME_W-1:0]  now_ms;
	} cmd_t;

	typedef struct packed {
		logic              event_valid;
		logic [CODE_W-1:0] event_code;
		logic              event_pressed;
		logic [CNT_W-1:0]  queued_count;
	} result_t;

endpackage

`default_nettype wire

[sv/button_event_scanner_fifo_unit.sv]
// Top level: button event scanner with an event queue behind a request queue.
// The back end takes a new request only when idle, after the last one is done and while the result
// queue has room; a sample steps the scan sequencer through every button, and a pop reads the event
// memory through its registered read port.
// Reset clears queues, pointers, button states and registers; the event memory is not cleared.
`default_nettype none

module button_event_scanner_fifo_unit #(
	parameter int NUM_BUTTONS = bes_pkg::NUM_BUTTONS_DEF,
	parameter int QUEUE_DEPTH = bes_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bes_pkg::APB_AW-1:0]  paddr,
	input  logic [bes_pkg::APB_DW-1:0]  pwdata,
	output logic [bes_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic                        operation,
	input  logic [bes_pkg::LEVEL_W-1:0] button_levels,
	input  logic [bes_pkg::TIME_W-1:0]  now_ms,
	output logic                        empty,
	input  logic                        pop,
	output logic                        event_valid,
	output logic [bes_pkg::CODE_W-1:0]  event_code,
	output logic                        event_pressed,
	output logic [bes_pkg::CNT_W-1:0]   queued_count
);
	import bes_pkg::*;

	cmd_t    push_cmd;
	cmd_t    cmd;
	logic    cmd_avail;
	logic    cmd_take;
	cfg_t    cfg;
	result_t res;

	assign push_cmd.operation     = operation;
	assign push_cmd.button_levels = button_levels;
	assign push_cmd.now_ms        = now_ms;

	bes_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.push      (push),
		.full      (full),
		.push_cmd  (push_cmd),
		.cmd_avail (cmd_avail),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.cfg       (cfg)
	);

	bes_back #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_avail (cmd_avail),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign event_valid   = res.event_valid;
	assign event_code    = res.event_code;
	assign event_pressed = res.event_pressed;
	assign queued_count  = res.queued_count;

endmodule

`default_nettype wire

[sv/bes_front.sv]
// Front end: configuration registers on the APB-style port and a two-entry
// request queue that decouples input from the back end. Depends on bes_pkg.
`default_nettype none

module bes_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bes_pkg::APB_AW-1:0]  paddr,
	input  logic [bes_pkg::APB_DW-1:0]  pwdata,
	output logic [bes_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  bes_pkg::cmd_t               push_cmd,
	output logic                        cmd_avail,
	output bes_pkg::cmd_t               cmd,
	input  logic                        cmd_take,
	output bes_pkg::cfg_t               cfg
);
	import bes_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_we;
	cfg_t                 cfg_q;
	cmd_t                 slot_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 push_ok;

	assign reg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIN_REGS; i++) begin
				cfg_q.pin_code[i] <= CODE_W'(i);
			end
			cfg_q.debounce_ms    <= DEB_W'(50);
			cfg_q.events_enabled <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_PIN0:     cfg_q.pin_code[0]    <= pwdata[CODE_W-1:0];
				REG_PIN1:     cfg_q.pin_code[1]    <= pwdata[CODE_W-1:0];
				REG_PIN2:     cfg_q.pin_code[2]    <= pwdata[CODE_W-1:0];
				REG_PIN3:     cfg_q.pin_code[3]    <= pwdata[CODE_W-1:0];
				REG_DEBOUNCE: cfg_q.debounce_ms    <= pwdata[DEB_W-1:0];
				REG_ENABLE:   cfg_q.events_enabled <= pwdata[0];
				default:      cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PIN0:     prdata = APB_DW'(cfg_q.pin_code[0]);
			REG_PIN1:     prdata = APB_DW'(cfg_q.pin_code[1]);
			REG_PIN2:     prdata = APB_DW'(cfg_q.pin_code[2]);
			REG_PIN3:     prdata = APB_DW'(cfg_q.pin_code[3]);
			REG_DEBOUNCE: prdata = APB_DW'(cfg_q.debounce_ms);
			REG_ENABLE:   prdata = APB_DW'(cfg_q.events_enabled);
			default:      prdata = '0;
		endcase
	end

	assign full      = (fill_q == 2'd2);
	assign cmd_avail = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push_ok   = push & ~full;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push_ok} - {1'b0, cmd_take};
		end
	end

endmodule

`default_nettype wire

[sv/bes_back.sv]
// Back end: button scan sequencer, event ring memory with debounce filter,
// and a two-entry result queue. Depends on bes_pkg.
`default_nettype none

module bes_back #(
	parameter int NUM_BUTTONS = bes_pkg::NUM_BUTTONS_DEF,
	parameter int QUEUE_DEPTH = bes_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bes_pkg::cfg_t    cfg,
	input  logic             cmd_avail,
	input  bes_pkg::cmd_t    cmd,
	output logic             cmd_take,
	output logic             empty,
	input  logic             pop,
	output bes_pkg::result_t res
);
	import bes_pkg::*;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int BIDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int CW     = (PTR_W > CNT_W) ? PTR_W : CNT_W;
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [BIDX_W-1:0] IDX_LAST = BIDX_W'(NUM_BUTTONS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]             state_q;
	logic [BIDX_W-1:0]      idx_q;
	logic [NUM_BUTTONS-1:0] pressed_q;
	logic [PTR_W-1:0]       wp_q;
	logic [PTR_W-1:0]       rp_q;
	logic [TIME_W-1:0]      last_time_q;
	logic [CODE_W-1:0]      last_code_q;
	logic [LEVEL_W-1:0]     levels_q;
	logic [TIME_W-1:0]      now_q;
	logic [CODE_W:0]        mem [QUEUE_DEPTH];
	logic [CODE_W:0]        rd_q;

	logic [LEVEL_W-1:0]     pressed_ext;
	logic                   cur_pressed;
	logic                   changed;
	logic [CODE_W-1:0]      ev_code;
	logic [TIME_W-1:0]      elapsed;
	logic                   suppress;
	logic                   accept_ev;
	logic [PTR_W-1:0]       wp_next;
	logic [PTR_W-1:0]       rp_next;
	logic                   ring_full;
	logic                   mem_we;
	logic [PTR_W:0]         count_wide;
	logic [PTR_W-1:0]       ring_count;
	logic                   res_push;
	result_t                res_data;

	result_t                rq_slot_q [2];
	logic                   rq_wr_q;
	logic                   rq_rd_q;
	logic [1:0]             rq_fill_q;
	logic                   resq_full;
	logic                   res_pop;

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [PTR_W-1:0] c);
		logic [CW-1:0] ext;
		ext = CW'(c);
		return (ext > CW'(CNT_MAX)) ? CNT_MAX : CNT_W'(ext);
	endfunction

	assign pressed_ext = LEVEL_W'(pressed_q);
	assign cur_pressed = ~levels_q[2'(idx_q)];
	assign changed     = cur_pressed != pressed_ext[2'(idx_q)];
	assign ev_code     = cfg.pin_code[2'(idx_q)] + CODE_OFFSET;
	assign elapsed     = now_q - last_time_q;
	assign suppress    = (elapsed < TIME_W'(cfg.debounce_ms)) && (ev_code == last_code_q);
	assign accept_ev   = (state_q == ST_SCAN) && changed && cfg.events_enabled && !suppress;

	assign wp_next   = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_next   = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign ring_full = (wp_next == rp_q);
	assign mem_we    = accept_ev && !ring_full;

	assign count_wide = (wp_q >= rp_q) ? ({1'b0, wp_q} - {1'b0, rp_q})
		: ((PTR_W + 1)'(QUEUE_DEPTH) + {1'b0, wp_q} - {1'b0, rp_q});
	assign ring_count = count_wide[PTR_W-1:0];

	assign cmd_take = (state_q == ST_IDLE) && cmd_avail && !resq_full;
	assign res_push = (state_q == ST_DONE) || (state_q == ST_POP);

	always_comb begin
		res_data = '0;
		if (state_q == ST_POP) begin
			res_data.event_valid   = 1'b1;
			res_data.event_code    = rd_q[CODE_W-1:0];
			res_data.event_pressed = rd_q[CODE_W];
			res_data.queued_count  = sat_cnt(ring_count - 1'b1);
		end else begin
			res_data.queued_count  = sat_cnt(ring_count);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= {cur_pressed, ev_code};
		end
		rd_q <= mem[rp_q];
		if (cmd_take) begin
			levels_q <= cmd.button_levels;
			now_q    <= cmd.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pressed_q   <= '0;
			wp_q        <= '0;
			rp_q        <= '0;
			last_time_q <= '0;
			last_code_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						idx_q <= '0;
						if (cmd.operation == OP_SAMPLE) begin
							state_q <= ST_SCAN;
						end else if (wp_q != rp_q) begin
							state_q <= ST_POP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (changed) begin
						pressed_q[idx_q] <= cur_pressed;
					end
					if (accept_ev) begin
						last_code_q <= ev_code;
						last_time_q <= now_q;
					end
					if (mem_we) begin
						wp_q <= wp_next;
					end
					if (idx_q == IDX_LAST) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_POP: begin
					rp_q    <= rp_next;
					state_q <= ST_IDLE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign resq_full = (rq_fill_q == 2'd2);
	assign empty     = (rq_fill_q == 2'd0);
	assign res       = rq_slot_q[rq_rd_q];
	assign res_pop   = pop & ~empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_slot_q[rq_wr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q   <= 1'b0;
			rq_rd_q   <= 1'b0;
			rq_fill_q <= 2'd0;
		end else begin
			if (res_push) begin
				rq_wr_q <= ~rq_wr_q;
			end
			if (res_pop) begin
				rq_rd_q <= ~rq_rd_q;
			end
			rq_fill_q <= rq_fill_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> (wp_q != rp_q))
		else $error("Pop state entered with an empty event ring.");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !resq_full)
		else $error("Result queue overflow.");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> (state_q == ST_SCAN || state_q == ST_DONE))
		else $error("Scan left for an unexpected state.");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (wp_q != rp_q))
		else $error("Event ring empty right after a push.");

endmodule

`default_nettype wire

[tb/sv/button_event_scanner_fifo_unit_tb.sv]
// Self-checking testbench for button_event_scanner_fifo_unit: drives sample and pop
// requests and APB register writes, and predicts every result with its own scanner model.
// Depends on bes_pkg and the button_event_scanner_fifo_unit RTL.
`default_nettype none

module button_event_scanner_fifo_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bes_pkg::*;

	localparam int N_BUTTONS      = NUM_BUTTONS_DEF;
	localparam int EVENT_SLOTS    = QUEUE_DEPTH_DEF - 1;
	localparam int SETTLE_CYCLES  = NUM_BUTTONS_DEF + 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 40;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                push;
	logic                full;
	logic                operation;
	logic [LEVEL_W-1:0]  button_levels;
	logic [TIME_W-1:0]   now_ms;
	logic                empty;
	logic                pop;
	logic                event_valid;
	logic [CODE_W-1:0]   event_code;
	logic                event_pressed;
	logic [CNT_W-1:0]    queued_count;

	// Scanner model: configuration, button states and the event queue.
	logic [CODE_W-1:0]   pin_model [PIN_REGS];
	logic [DEB_W-1:0]    debounce_model;
	logic                enable_model;
	logic [LEVEL_W-1:0]  held_buttons;
	logic [CODE_W:0]     queued_events [$];
	logic [TIME_W-1:0]   last_event_time;
	logic [CODE_W-1:0]   last_event_code;

	result_t             expected_results [$];
	result_t             oldest_result;
	int                  error_count = 0;
	int                  stall_cycles = 0;
	bit                  no_idle = 1'b0;
	int                  pop_stall = 0;
	logic [TIME_W-1:0]   clock_ms = '0;
	logic [LEVEL_W-1:0]  last_levels = '1;

	button_event_scanner_fifo_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.button_levels (button_levels),
		.now_ms        (now_ms),
		.empty         (empty),
		.pop           (pop),
		.event_valid   (event_valid),
		.event_code    (event_code),
		.event_pressed (event_pressed),
		.queued_count  (queued_count)
	);

	always #6 clk = ~clk;

	function automatic int idle_gap();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [APB_DW-1:0] register_value(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_PIN0, REG_PIN1, REG_PIN2, REG_PIN3: begin
				return {{(APB_DW-CODE_W){1'b0}}, pin_model[idx[1:0]]};
			end
			REG_DEBOUNCE: begin
				return {{(APB_DW-DEB_W){1'b0}}, debounce_model};
			end
			default: begin
				return {{(APB_DW-1){1'b0}}, enable_model};
			end
		endcase
	endfunction

	// Walks the buttons in index order for a sample, or pops the model queue for a pop, and queues the expected result.
	task automatic predict_result(input cmd_t req);
		result_t          r;
		logic             now_pressed;
		logic [CODE_W-1:0] code;
		logic [CODE_W:0]  ev;
		r = '0;
		if (req.operation == OP_SAMPLE) begin
			for (int i = 0; i < N_BUTTONS; i++) begin
				now_pressed = ~req.button_levels[i];
				if (now_pressed != held_buttons[i]) begin
					held_buttons[i] = now_pressed;
					code = pin_model[i] + CODE_OFFSET;
					if (enable_model && !((req.now_ms - last_event_time) <
							{{(TIME_W-DEB_W){1'b0}}, debounce_model} &&
							code == last_event_code)) begin
						if (queued_events.size() < EVENT_SLOTS) begin
							queued_events.push_back({now_pressed, code});
						end
						last_event_code = code;
						last_event_time = req.now_ms;
					end
				end
			end
		end else if (queued_events.size() != 0) begin
			ev = queued_events.pop_front();
			r.event_valid   = 1'b1;
			r.event_code    = ev[CODE_W-1:0];
			r.event_pressed = ev[CODE_W];
		end
		r.queued_count = (queued_events.size() > CNT_MAX) ? CNT_MAX : CNT_W'(queued_events.size());
		expected_results.push_back(r);
	endtask

	task automatic send_request(input cmd_t req);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation     = req.operation;
		button_levels = req.button_levels;
		now_ms        = req.now_ms;
		push          = 1'b1;
		do @(posedge clk); while (full);
		predict_result(req);
	endtask

	task automatic send_sample(input logic [LEVEL_W-1:0] levels, input logic [TIME_W-1:0] t);
		cmd_t req;
		req.operation     = OP_SAMPLE;
		req.button_levels = levels;
		req.now_ms        = t;
		send_request(req);
	endtask

	task automatic send_pop();
		cmd_t req;
		req.operation     = OP_POP;
		req.button_levels = LEVEL_W'($urandom());
		req.now_ms        = $urandom();
		send_request(req);
	endtask

	function automatic cmd_t random_request(input int pop_pct, input int span);
		cmd_t req;
		int   r;
		req.operation = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_SAMPLE;
		if ($urandom_range(0, 99) < 60) begin
			last_levels[2'($urandom_range(0, N_BUTTONS - 1))] ^= 1'b1;
		end else begin
			last_levels = LEVEL_W'($urandom());
		end
		req.button_levels = last_levels;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			clock_ms += $urandom_range(0, span);
		end else if (r < 90) begin
			clock_ms += $urandom_range(0, 3);
		end else begin
			clock_ms = $urandom();
		end
		req.now_ms = clock_ms;
		return req;
	endfunction

	task automatic hold_until_drained();
		@(negedge clk);
		push = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic wait_idle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_read(input logic [REG_IDX_W-1:0] idx);
		logic [APB_DW-1:0] want;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		want = register_value(idx);
		if (prdata !== want) begin
			error_count++;
			$display("%0t: register %0d read expected %0h got %0h", $time, idx, want, prdata);
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PIN0, REG_PIN1, REG_PIN2, REG_PIN3: pin_model[idx[1:0]] = value[CODE_W-1:0];
			REG_DEBOUNCE: debounce_model = value[DEB_W-1:0];
			REG_ENABLE: enable_model = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (idx <= REG_ENABLE) begin
			cfg_read(idx);
		end
	endtask

	task automatic check_field(input string name, input logic [CODE_W-1:0] want,
			input logic [CODE_W-1:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= REPORT_LIMIT) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		end
	endtask

	task automatic test_reset_values();
		for (int i = 0; i <= REG_ENABLE; i++) begin
			cfg_read(REG_IDX_W'(i));
		end
		send_sample(4'h0, 32'd5);
		send_pop();
		send_sample(4'hF, 32'd6);
		send_pop();
	endtask

	task automatic test_event_basics();
		wait_idle();
		cfg_write(REG_ENABLE, 32'd1);
		send_sample(4'b1110, 32'd1000);
		send_sample(4'b1111, 32'd1010);
		send_sample(4'b1110, 32'd1060);
		send_sample(4'b0000, 32'd1061);
		repeat (3) send_pop();
		send_sample(4'b0111, 32'd1062);
		send_sample(4'b1111, 32'd1070);
		send_sample(4'b1110, 32'hFFFF_FFF0);
		send_sample(4'b1111, 32'h0000_0010);
		send_sample(4'b1110, 32'h0000_0030);
		repeat (8) send_pop();
	endtask

	task automatic test_queue_overflow();
		wait_idle();
		cfg_write(REG_DEBOUNCE, 32'd0);
		for (int i = 0; i < 10; i++) begin
			send_sample((i % 2 == 0) ? 4'h0 : 4'hF, 32'd2000 + i);
		end
		repeat (EVENT_SLOTS + 2) send_pop();
	endtask

	task automatic test_config_extremes();
		logic [CODE_W-1:0] pin;
		logic [DEB_W-1:0]  deb;
		for (int k = 0; k < 6; k++) begin
			wait_idle();
			for (int i = 0; i < PIN_REGS; i++) begin
				pin = (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : CODE_W'($urandom_range(0, 255));
				cfg_write(REG_IDX_W'(i), {$urandom()} & 32'hFFFF_FF00 | pin);
			end
			deb = (k == 0) ? 16'h0000 : (k == 1 || k == 5) ? 16'hFFFF :
				(k == 2) ? 16'h0001 : DEB_W'($urandom_range(0, 65535));
			cfg_write(REG_DEBOUNCE, {$urandom()} & 32'hFFFF_0000 | deb);
			cfg_write(REG_ENABLE, {$urandom()} & 32'hFFFF_FFFE | ((k == 3) ? 1'b0 : 1'b1));
			if (k == 0) begin
				cfg_write(REG_SPARE_A, $urandom());
				cfg_write(REG_SPARE_B, $urandom());
			end
			for (int n = 0; n < 60; n++) begin
				send_request(random_request(45, 2 * deb + 4));
			end
		end
	endtask

	task automatic test_random_traffic();
		int pop_pct [6] = '{35, 50, 20, 65, 45, 50};
		int deb;
		for (int b = 0; b < 6; b++) begin
			wait_idle();
			for (int i = 0; i < PIN_REGS; i++) begin
				cfg_write(REG_IDX_W'(i), (b == 4) ? 32'd7 : $urandom_range(0, 255));
			end
			deb = $urandom_range(0, 120);
			cfg_write(REG_DEBOUNCE, deb);
			cfg_write(REG_ENABLE, 32'd1);
			no_idle = (b == 2);
			for (int n = 0; n < 210; n++) begin
				if (b == 3 && n == 100) begin
					hold_until_drained();
				end
				send_request(random_request(pop_pct[b], 2 * deb + 4));
			end
			no_idle = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				error_count++;
				$display("%0t: result with no request waiting, code %0h", $time, event_code);
			end else begin
				oldest_result = expected_results.pop_front();
				check_field("event_valid", CODE_W'(oldest_result.event_valid),
					CODE_W'(event_valid));
				check_field("event_code", oldest_result.event_code, event_code);
				check_field("event_pressed", CODE_W'(oldest_result.event_pressed),
					CODE_W'(event_pressed));
				check_field("queued_count", CODE_W'(oldest_result.queued_count),
					CODE_W'(queued_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (pop_stall > 0) begin
				pop = 1'b0;
				pop_stall--;
			end else begin
				pop = 1'b1;
				pop_stall = idle_gap();
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		push          = 1'b0;
		operation     = OP_SAMPLE;
		button_levels = '1;
		now_ms        = '0;
		for (int i = 0; i < PIN_REGS; i++) begin
			pin_model[i] = CODE_W'(i);
		end
		debounce_model  = DEB_W'(50);
		enable_model    = 1'b0;
		held_buttons    = '0;
		last_event_time = '0;
		last_event_code = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_event_basics();
		test_queue_overflow();
		test_config_extremes();
		test_random_traffic();

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
